FILE: hdl/vitc_twb_pkg.sv
package vitc_twb_pkg;

  // Frame rates selected by video_system
  localparam logic [5:0] FPS_PAL  = 6'd25;
  localparam logic [5:0] FPS_NTSC = 6'd30;
  localparam logic [6:0] SIXTY    = 7'd60;
  localparam logic [4:0] DAY_HRS  = 5'd24;

  // Reciprocals floor(2^S / d); with the operand ranges used here the estimate
  // lands on q or q-1, and one compare/subtract step fixes it up.
  localparam logic [27:0] RECIP_25 = 28'd171798691;  // 2^32 / 25
  localparam logic [27:0] RECIP_30 = 28'd143165576;  // 2^32 / 30
  localparam logic [26:0] RECIP_60 = 27'd71582788;   // 2^32 / 60
  localparam logic [15:0] RECIP_24 = 16'd43690;      // 2^20 / 24

  // Number of register stages in the arithmetic pipeline
  localparam int unsigned NSTG = 9;

  // Group positions within one run
  localparam logic [3:0] GRP_FRAMES  = 4'd0;
  localparam logic [3:0] GRP_SECONDS = 4'd1;
  localparam logic [3:0] GRP_MINUTES = 4'd2;
  localparam logic [3:0] GRP_HOURS   = 4'd3;
  localparam logic [3:0] GRP_LAST    = 4'd8;

  localparam logic [1:0] SYNC_PAIR = 2'b01;  // 1 then 0, LSB first

  // BCD of a value below 60: tens = (v * 13) >> 7 is exact there
  function automatic logic [7:0] to_bcd(input logic [5:0] v);
    logic [9:0] prod;
    logic [3:0] tens;
    logic [5:0] ones;
    prod = 10'(v) * 10'd13;
    tens = 4'(prod[9:7]);
    ones = v - 6'(tens) * 6'd10;
    return {tens, ones[3:0]};
  endfunction

  function automatic logic [9:0] make_group(input logic [7:0] b);
    return {b, SYNC_PAIR};
  endfunction

  // XOR of the ten bytes formed by the first 80 serialized bits
  function automatic logic [7:0] check_byte(input logic [7:0] b0, input logic [7:0] b1,
                                            input logic [7:0] b2, input logic [7:0] b3);
    logic [79:0] stream;
    logic [7:0]  acc;
    stream = {make_group(8'h00), make_group(8'h00), make_group(8'h00), make_group(8'h00),
              make_group(b3), make_group(b2), make_group(b1), make_group(b0)};
    acc = 8'h00;
    for (int k = 0; k < 10; k++) begin
      acc = acc ^ stream[8*k +: 8];
    end
    return acc;
  endfunction

endpackage

FILE: hdl/vitc_timecode_word_builder.sv
// Path: an accepted frame count moves through stages 0 to 8 into the output group register.
// Throughput: nine group beats per frame count, one per cycle while out_ready_i is high;
//   the output group register, which holds one run at a time, is the limit.
// The 9-stage division pipeline keeps accepting counts while a run is still going out.
// Reset (rst_ni low, asynchronous): pipeline and output emptied, video_system = 25 fps.
module vitc_timecode_word_builder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [30:0] frame_count_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [9:0]  group_bits_o,
  output logic [3:0]  group_index_o,
  output logic        is_last_o
);
  import vitc_twb_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration: 0 = 25 fps, 1 = 30 fps
  // ---------------------------------------------------------------------------
  logic video_system_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      video_system_q <= 1'b0;
    end else if (cfg_we_i) begin
      video_system_q <= cfg_wdata_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control. Each stage loads when it is empty or when the stage
  // after it loads, so bubbles collapse and the chain only stalls on the
  // output side.
  // ---------------------------------------------------------------------------
  logic [NSTG-1:0] vld_q;
  logic [NSTG-1:0] ld;
  logic            ser_vld_q;
  logic [3:0]      ser_idx_q;
  logic            ser_take;   // output register can take a new run
  logic            out_beat;

  assign out_beat = ser_vld_q && out_ready_i;
  assign ser_take = !ser_vld_q || (out_ready_i && (ser_idx_q == GRP_LAST));

  always_comb begin
    ld[NSTG-1] = !vld_q[NSTG-1] || ser_take;
    for (int k = NSTG - 2; k >= 0; k--) begin
      ld[k] = !vld_q[k] || ld[k+1];
    end
  end

  assign in_ready_o = ld[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (ld[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (ld[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: input register. Rate select is captured with the count.
  // ---------------------------------------------------------------------------
  logic [30:0] cnt0_q;
  logic        sys0_q;

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      cnt0_q <= frame_count_i;
      sys0_q <= video_system_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: count * 2^32/fps
  // ---------------------------------------------------------------------------
  logic [58:0] prod1_d, prod1_q;
  logic [30:0] cnt1_q;
  logic        sys1_q;

  assign prod1_d = 59'(cnt0_q) * 59'(sys0_q ? RECIP_30 : RECIP_25);

  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      prod1_q <= prod1_d;
      cnt1_q  <= cnt0_q;
      sys1_q  <= sys0_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: total seconds and frames, with one-step correction
  // ---------------------------------------------------------------------------
  logic [26:0] q1_est;
  logic [30:0] q1_mul;
  logic [30:0] r1_full;
  logic [5:0]  r1, fps1;
  logic [26:0] tsec2_d, tsec2_q;
  logic [4:0]  fr2_d, fr2_q;

  always_comb begin
    q1_est  = prod1_q[58:32];
    fps1    = sys1_q ? FPS_NTSC : FPS_PAL;
    q1_mul  = sys1_q ? (31'(q1_est) * 31'(FPS_NTSC)) : (31'(q1_est) * 31'(FPS_PAL));
    r1_full = cnt1_q - q1_mul;
    r1      = r1_full[5:0];  // below 2 * fps
    if (r1 >= fps1) begin
      tsec2_d = q1_est + 27'd1;
      fr2_d   = 5'(r1 - fps1);
    end else begin
      tsec2_d = q1_est;
      fr2_d   = 5'(r1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[2]) begin
      tsec2_q <= tsec2_d;
      fr2_q   <= fr2_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: total seconds * 2^32/60
  // ---------------------------------------------------------------------------
  logic [53:0] prod3_q;
  logic [26:0] tsec3_q;
  logic [4:0]  fr3_q;

  always_ff @(posedge clk_i) begin
    if (ld[3]) begin
      prod3_q <= 54'(tsec2_q) * 54'(RECIP_60);
      tsec3_q <= tsec2_q;
      fr3_q   <= fr2_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: total minutes and seconds
  // ---------------------------------------------------------------------------
  logic [20:0] q3_est;
  logic [26:0] r3_full;
  logic [6:0]  r3;
  logic [20:0] tmin4_d, tmin4_q;
  logic [5:0]  sec4_d, sec4_q;
  logic [4:0]  fr4_q;

  always_comb begin
    q3_est  = prod3_q[52:32];  // total minutes stay below 2^21
    r3_full = tsec3_q - 27'(q3_est) * 27'(SIXTY);
    r3      = r3_full[6:0];
    if (r3 >= SIXTY) begin
      tmin4_d = q3_est + 21'd1;
      sec4_d  = 6'(r3 - SIXTY);
    end else begin
      tmin4_d = q3_est;
      sec4_d  = 6'(r3);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[4]) begin
      tmin4_q <= tmin4_d;
      sec4_q  <= sec4_d;
      fr4_q   <= fr3_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: total minutes * 2^32/60
  // ---------------------------------------------------------------------------
  logic [47:0] prod5_q;
  logic [20:0] tmin5_q;
  logic [5:0]  sec5_q;
  logic [4:0]  fr5_q;

  always_ff @(posedge clk_i) begin
    if (ld[5]) begin
      prod5_q <= 48'(tmin4_q) * 48'(RECIP_60);
      tmin5_q <= tmin4_q;
      sec5_q  <= sec4_q;
      fr5_q   <= fr4_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: total hours and minutes
  // ---------------------------------------------------------------------------
  logic [14:0] q5_est;
  logic [20:0] r5_full;
  logic [6:0]  r5;
  logic [14:0] thr6_d, thr6_q;
  logic [5:0]  min6_d, min6_q;
  logic [5:0]  sec6_q;
  logic [4:0]  fr6_q;

  always_comb begin
    q5_est  = prod5_q[46:32];  // total hours stay below 2^15
    r5_full = tmin5_q - 21'(q5_est) * 21'(SIXTY);
    r5      = r5_full[6:0];
    if (r5 >= SIXTY) begin
      thr6_d = q5_est + 15'd1;
      min6_d = 6'(r5 - SIXTY);
    end else begin
      thr6_d = q5_est;
      min6_d = 6'(r5);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[6]) begin
      thr6_q <= thr6_d;
      min6_q <= min6_d;
      sec6_q <= sec5_q;
      fr6_q  <= fr5_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 7: total hours * 2^20/24
  // ---------------------------------------------------------------------------
  logic [30:0] prod7_q;
  logic [14:0] thr7_q;
  logic [5:0]  min7_q, sec7_q;
  logic [4:0]  fr7_q;

  always_ff @(posedge clk_i) begin
    if (ld[7]) begin
      prod7_q <= 31'(thr6_q) * 31'(RECIP_24);
      thr7_q  <= thr6_q;
      min7_q  <= min6_q;
      sec7_q  <= sec6_q;
      fr7_q   <= fr6_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 8: hours modulo 24
  // ---------------------------------------------------------------------------
  logic [9:0]  q7_est;
  logic [14:0] r7_full;
  logic [5:0]  r7;
  logic [4:0]  hr8_d, hr8_q;
  logic [5:0]  min8_q, sec8_q;
  logic [4:0]  fr8_q;

  always_comb begin
    q7_est  = prod7_q[29:20];
    r7_full = thr7_q - 15'(q7_est) * 15'(DAY_HRS);
    r7      = r7_full[5:0];
    if (r7 >= 6'(DAY_HRS)) begin
      hr8_d = 5'(r7 - 6'(DAY_HRS));
    end else begin
      hr8_d = 5'(r7);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[8]) begin
      hr8_q  <= hr8_d;
      min8_q <= min7_q;
      sec8_q <= sec7_q;
      fr8_q  <= fr7_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: BCD bytes and check byte of one run, sent one group per beat.
  // User bytes are always zero.
  // ---------------------------------------------------------------------------
  logic [7:0] bcd_fr, bcd_sec, bcd_min, bcd_hr;
  logic [7:0] byte_fr_q, byte_sec_q, byte_min_q, byte_hr_q, byte_chk_q;
  logic [7:0] cur_byte;

  assign bcd_fr  = to_bcd(6'(fr8_q));
  assign bcd_sec = to_bcd(sec8_q);
  assign bcd_min = to_bcd(min8_q);
  assign bcd_hr  = to_bcd(6'(hr8_q));

  always_ff @(posedge clk_i) begin
    if (ser_take && vld_q[NSTG-1]) begin
      byte_fr_q  <= bcd_fr;
      byte_sec_q <= bcd_sec;
      byte_min_q <= bcd_min;
      byte_hr_q  <= bcd_hr;
      byte_chk_q <= check_byte(bcd_fr, bcd_sec, bcd_min, bcd_hr);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_vld_q <= 1'b0;
      ser_idx_q <= GRP_FRAMES;
    end else if (ser_take) begin
      ser_vld_q <= vld_q[NSTG-1];
      ser_idx_q <= GRP_FRAMES;
    end else if (out_beat) begin
      ser_idx_q <= ser_idx_q + 4'd1;
    end
  end

  always_comb begin
    case (ser_idx_q)
      GRP_FRAMES:  cur_byte = byte_fr_q;
      GRP_SECONDS: cur_byte = byte_sec_q;
      GRP_MINUTES: cur_byte = byte_min_q;
      GRP_HOURS:   cur_byte = byte_hr_q;
      GRP_LAST:    cur_byte = byte_chk_q;
      default:     cur_byte = 8'h00;
    endcase
  end

  assign out_valid_o   = ser_vld_q;
  assign group_bits_o  = make_group(cur_byte);
  assign group_index_o = ser_idx_q;
  assign is_last_o     = (ser_idx_q == GRP_LAST);

endmodule

FILE: hdl/vitc_twb_checker.sv
module vitc_twb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [9:0] group_bits_i,
  input logic [3:0] group_index_i,
  input logic       is_last_i
);
  import vitc_twb_pkg::*;

  // Stalled beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(group_bits_i)
      && $stable(group_index_i))
    else $error("stalled beat changed");

  // Last flag marks exactly the check group
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (is_last_i == (group_index_i == GRP_LAST)))
    else $error("is_last does not match group index");

  // Every group opens with the sync pair
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (group_bits_i[1:0] == SYNC_PAIR))
    else $error("missing sync pair");

  // Within a run groups follow one another without gaps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !is_last_i |=>
      out_valid_i && (group_index_i == $past(group_index_i) + 4'd1))
    else $error("group sequence broken");

  // A new run starts at the first group
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && is_last_i |=> !out_valid_i || (group_index_i == GRP_FRAMES))
    else $error("run did not restart at group zero");

endmodule

bind vitc_timecode_word_builder vitc_twb_checker u_vitc_twb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .group_bits_i  (group_bits_o),
  .group_index_i (group_index_o),
  .is_last_i     (is_last_o)
);

FILE: tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Run length guard. Slowest legal run: about 230 counts x 9 group beats,
  // each beat held off by the longest receiver stall, plus the longest sender
  // gaps and one long receiver hold; CycleLimit leaves margin over that total.
  localparam int unsigned CycleLimit  = 500_000;
  // Pause after the last expected beat
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned MaxPrinted  = 40;

  // video_system register values
  localparam logic VsPal  = 1'b0;
  localparam logic VsNtsc = 1'b1;

  // One group beat as seen on the output channel
  typedef struct packed {
    logic [9:0] bits;
    logic [3:0] index;
    logic       last;
  } group_beat_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic        cfg_wdata_i   = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_ready_o;
  logic [30:0] frame_count_i = '0;
  logic        out_valid_o;
  logic        out_ready_i   = 1'b0;
  logic [9:0]  group_bits_o;
  logic [3:0]  group_index_o;
  logic        is_last_o;

  // Group beats predicted for accepted counts, oldest first
  group_beat_t pending_groups[$];
  // Our copy of the video_system register
  logic        video_system_q = VsPal;

  int unsigned mismatch_count   = 0;
  int unsigned cycle_count      = 0;
  // Sender runs back-to-back when set
  bit          no_gap_mode      = 1'b0;
  // Long receiver hold requested by a test, consumed by the sink process
  int unsigned hold_off_request = 0;

  always #1ns clk_i = ~clk_i;

  vitc_timecode_word_builder i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .frame_count_i (frame_count_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .group_bits_o  (group_bits_o),
    .group_index_o (group_index_o),
    .is_last_o     (is_last_o)
  );

  // ---------------------------------------------------------------------------
  // Timecode predictor
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] bcd_byte(input int unsigned v);
    return {4'(v / 10), 4'(v % 10)};
  endfunction

  // Split the count into hh:mm:ss:ff at the current rate, pack BCD bytes,
  // add four zero user bytes and the check byte, queue nine beats.
  function automatic void predict_timecode(input logic [30:0] count);
    int unsigned fps, total_sec, total_min;
    logic [7:0]  tc_bytes [8];
    logic [9:0]  groups [9];
    logic [79:0] serial;
    logic [7:0]  check;
    group_beat_t beat;
    fps       = (video_system_q == VsNtsc) ? int'(vitc_twb_pkg::FPS_NTSC)
                                           : int'(vitc_twb_pkg::FPS_PAL);
    total_sec = count / fps;
    total_min = total_sec / 60;
    tc_bytes[0] = bcd_byte(count % fps);
    tc_bytes[1] = bcd_byte(total_sec % 60);
    tc_bytes[2] = bcd_byte(total_min % 60);
    tc_bytes[3] = bcd_byte((total_min / 60) % 24);
    for (int i = 4; i < 8; i++) begin
      tc_bytes[i] = 8'h00;
    end
    for (int i = 0; i < 8; i++) begin
      groups[i] = {tc_bytes[i], vitc_twb_pkg::SYNC_PAIR};
    end
    // bits go out LSB first, ten per group; regroup the first 80 into bytes
    for (int k = 0; k < 80; k++) begin
      serial[k] = groups[k / 10][k % 10];
    end
    check = 8'h00;
    for (int b = 0; b < 10; b++) begin
      check ^= serial[8*b +: 8];
    end
    groups[8] = {check, vitc_twb_pkg::SYNC_PAIR};
    for (int i = 0; i < 9; i++) begin
      beat.bits  = groups[i];
      beat.index = 4'(i);
      beat.last  = (4'(i) == vitc_twb_pkg::GRP_LAST);
      pending_groups = {pending_groups, beat};
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Shared helpers
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MaxPrinted) $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Mostly back-to-back or short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_gap_mode) return 0;
    r = $urandom_range(0, 15);
    if (r < 8) return 0;
    if (r < 14) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Entered and left at a falling edge. Valid stays high after the beat so a
  // zero-gap follow-up never lowers and raises it in the same step.
  task automatic send_frame_count(input logic [30:0] count);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    frame_count_i <= count;
    do @(posedge clk_i); while (!in_ready_o);
    predict_timecode(count);
    @(negedge clk_i);
  endtask

  // Stop offering counts and wait until every predicted beat has come out
  task automatic drain_groups();
    in_valid_i <= 1'b0;
    while (pending_groups.size() != 0) @(negedge clk_i);
  endtask

  // Register writes only with the block idle
  task automatic write_video_system(input logic value);
    drain_groups();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i       <= 1'b0;
    video_system_q  = value;
  endtask

  // Random count, weighted toward rollover points at the current rate
  function automatic logic [30:0] random_frame_count();
    longint unsigned fps, span, v;
    fps = (video_system_q == VsNtsc) ? 30 : 25;
    case ($urandom_range(0, 5))
      0: v = $urandom;
      1: v = $urandom_range(0, 9999);
      2: begin
        // around a minute or an hour boundary
        span = fps * 60 * ($urandom_range(0, 1) ? 60 : 1);
        v = span * $urandom_range(1, 2000) + $urandom_range(0, 4) - 2;
      end
      3: begin
        // around a day boundary, where hours wrap
        v = fps * 86400 * $urandom_range(1, 800) + $urandom_range(0, 4) - 2;
      end
      4: v = 64'h7FFF_FFFF - $urandom_range(0, 1000);
      default: v = $urandom_range(0, 32'(fps * 86400 - 1));
    endcase
    return v[30:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset rate (25 fps): frame, second, minute, hour and day rollovers,
  // the top of the count range and alternating bit patterns
  task automatic test_directed_pal();
    logic [30:0] counts [13];
    counts = '{31'd0, 31'd1, 31'd24, 31'd25, 31'd1499, 31'd1500, 31'd89999,
               31'd90000, 31'd2159999, 31'd2160000, 31'h7FFF_FFFF,
               31'h5555_5555, 31'h2AAA_AAAA};
    foreach (counts[i]) send_frame_count(counts[i]);
  endtask

  // The same rollover corners and the top of the count range at 30 fps
  task automatic test_directed_ntsc();
    logic [30:0] counts [10];
    counts = '{31'd29, 31'd30, 31'd1799, 31'd1800, 31'd107999, 31'd108000,
               31'd2591999, 31'd2592000, 31'h7FFF_FFFF, 31'h4000_0000};
    write_video_system(VsNtsc);
    foreach (counts[i]) send_frame_count(counts[i]);
  endtask

  // Random counts over several rate settings; odd phases run with no gaps
  task automatic test_random_counts();
    logic rates [6];
    rates = '{VsPal, VsNtsc, VsNtsc, VsPal, 1'b0, 1'b1};
    rates[4] = 1'($urandom_range(0, 1));
    rates[5] = 1'($urandom_range(0, 1));
    for (int phase = 0; phase < 6; phase++) begin
      write_video_system(rates[phase]);
      no_gap_mode = phase[0];
      repeat (30) send_frame_count(random_frame_count());
    end
    no_gap_mode = 1'b0;
  endtask

  // Receiver holds off for a long stretch while counts keep coming,
  // so the pipeline fills and in_ready_o drops
  task automatic test_output_backpressure();
    drain_groups();
    no_gap_mode      = 1'b1;
    hold_off_request = 300;
    repeat (30) send_frame_count(random_frame_count());
    no_gap_mode = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, stretches of full speed, and the long hold
  // ---------------------------------------------------------------------------
  initial begin : sink_proc
    int unsigned stall_left, hold_left, mode_left;
    bit          full_speed;
    stall_left = 0;
    hold_left  = 0;
    mode_left  = 0;
    full_speed = 1'b0;
    forever begin
      @(negedge clk_i);
      if (mode_left == 0) begin
        full_speed = ($urandom_range(0, 3) == 0);
        mode_left  = $urandom_range(50, 300);
      end else begin
        mode_left--;
      end
      if (hold_off_request != 0) begin
        hold_left        = hold_off_request;
        hold_off_request = 0;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (!full_speed && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        stall_left = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 29)
                                                  : $urandom_range(0, 2);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output check: every accepted beat against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_beat
    group_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_groups.size() == 0) begin
        report_mismatch($sformatf("unexpected beat bits=%h index=%0d last=%b",
                                  group_bits_o, group_index_o, is_last_o));
      end else begin
        want = pending_groups.pop_front();
        if (group_bits_o !== want.bits)
          report_mismatch($sformatf("group_bits got %h want %h (index %0d)",
                                    group_bits_o, want.bits, want.index));
        if (group_index_o !== want.index)
          report_mismatch($sformatf("group_index got %0d want %0d",
                                    group_index_o, want.index));
        if (is_last_o !== want.last)
          report_mismatch($sformatf("is_last got %b want %b (index %0d)",
                                    is_last_o, want.last, want.index));
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed_pal();
    test_directed_ntsc();
    test_random_counts();
    test_output_backpressure();

    drain_groups();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && pending_groups.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/vitc_twb_pkg.sv
hdl/vitc_timecode_word_builder.sv
hdl/vitc_twb_checker.sv
tb/testbench.sv
